// ===== hw/rtl/xppf_pkg.sv =====
package xppf_pkg;

  // Slot geometry and packet tracking limits
  localparam int PARITY_WORDS     = 40;
  localparam int MAX_PACKET_WORDS = 512;

  localparam int PW_AW  = (PARITY_WORDS > 1) ? $clog2(PARITY_WORDS) : 1;
  localparam int HLEN_W = $clog2(PARITY_WORDS + 1);
  localparam int WPOS_W = $clog2(MAX_PACKET_WORDS);

  localparam logic [31:0] PARITY_FLAG = 32'h8000_0000;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;

  localparam logic KIND_FORWARD = 1'b0;
  localparam logic KIND_PARITY  = 1'b1;

  // One output beat
  typedef struct packed {
    logic        packet_kind;
    logic [31:0] out_word;
    logic [2:0]  out_bytes;
    logic        out_last;
  } out_beat_t;

  // Clamp a byte count: codes above four count as four
  function automatic logic [2:0] valid_bytes(input logic [2:0] bc);
    valid_bytes = (bc > FULL_BYTES) ? FULL_BYTES : bc;
  endfunction

  // Keep the first n bytes of a big-endian word
  function automatic logic [31:0] byte_mask(input logic [2:0] n);
    logic [31:0] m;
    m = 32'h0000_0000;
    case (n)
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      3'd4:    m = 32'hFFFF_FFFF;
      default: m = 32'h0000_0000;
    endcase
    byte_mask = m;
  endfunction

endpackage

// ===== hw/rtl/xppf_in_if.sv =====
interface xppf_in_if;
  import xppf_pkg::*;

  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        end_of_packet;

  modport source(output valid, data_word, byte_count, end_of_packet, input ready);
  modport sink(input valid, data_word, byte_count, end_of_packet, output ready);
endinterface

// ===== hw/rtl/xppf_out_if.sv =====
interface xppf_out_if;
  import xppf_pkg::*;

  logic        valid;
  logic        ready;
  logic        packet_kind;
  logic [31:0] out_word;
  logic [2:0]  out_bytes;
  logic        out_last;

  modport source(output valid, packet_kind, out_word, out_bytes, out_last, input ready);
  modport sink(input valid, packet_kind, out_word, out_bytes, out_last, output ready);
endinterface

// ===== hw/rtl/xppf_store.sv =====
module xppf_store
  import xppf_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [PW_AW-1:0] waddr_i,
  input  logic [31:0]      wdata_i,
  input  logic             re_i,
  input  logic [PW_AW-1:0] raddr_i,
  output logic [31:0]      rdata_o
);

  logic [31:0] mem [PARITY_WORDS];
  logic [31:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/xor_pair_parity_fec_unit.sv =====
// Pairwise XOR parity generator. Every input beat is forwarded unchanged, one output beat per
// input beat: first the block accepts the word and reads the parity slot RAM, then it stores
// the word or XORs it with the slot word, writes it back and loads the output register, once
// that register is free. When an odd packet that pairs with the even packet in the slot ends,
// the block emits a parity packet of PARITY_WORDS+1 beats (header, then slot words), each slot
// word being a registered RAM read; input is not taken during that burst. No clearing pass
// follows reset: unwritten slot words are masked by the slot fill length.
module xor_pair_parity_fec_unit
  import xppf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  xppf_in_if.sink    in_i,
  xppf_out_if.source out_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WR   = 3'd1;
  localparam logic [2:0] S_PHDR = 3'd2;
  localparam logic [2:0] S_PRD  = 3'd3;
  localparam logic [2:0] S_PEM  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [31:0]       word_q;
  logic [2:0]        bc_q;
  logic              last_q;
  logic [31:0]       held_seq_q, held_seq_d;
  logic              held_valid_q, held_valid_d;
  logic [HLEN_W-1:0] held_len_q, held_len_d;
  logic [31:0]       cur_seq_q, cur_seq_d;
  logic [WPOS_W-1:0] wpos_q, wpos_d;
  logic              paired_q, paired_d;
  logic              even_q, even_d;
  logic [PW_AW-1:0]  par_idx_q, par_idx_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q, out_d;

  logic              accept;
  logic              out_free;
  logic              slot_hit;
  logic [2:0]        nbytes;
  logic [HLEN_W-1:0] wpos_h;
  logic [31:0]       masked;
  logic              mem_we;
  logic [PW_AW-1:0]  mem_waddr;
  logic [31:0]       mem_wdata;
  logic              mem_re;
  logic [PW_AW-1:0]  mem_raddr;
  logic [31:0]       mem_rdata;
  logic              par_last;

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.packet_kind = out_q.packet_kind;
  assign out_o.out_word    = out_q.out_word;
  assign out_o.out_bytes   = out_q.out_bytes;
  assign out_o.out_last    = out_q.out_last;

  // Payload word position inside the slot
  assign slot_hit = (wpos_q != '0) && (32'(wpos_q) <= 32'(PARITY_WORDS));
  assign wpos_h   = HLEN_W'(wpos_q);
  assign nbytes   = valid_bytes(bc_q);
  assign masked   = word_q & byte_mask(nbytes);
  assign par_last = (par_idx_q == PW_AW'(PARITY_WORDS - 1));

  xppf_store u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Sequencer and shared XOR datapath
  always_comb begin
    state_d      = state_q;
    held_seq_d   = held_seq_q;
    held_valid_d = held_valid_q;
    held_len_d   = held_len_q;
    cur_seq_d    = cur_seq_q;
    wpos_d       = wpos_q;
    paired_d     = paired_q;
    even_d       = even_q;
    par_idx_d    = par_idx_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_d        = out_q;
    mem_we       = 1'b0;
    mem_waddr    = PW_AW'(wpos_q - 1'b1);
    mem_wdata    = masked;
    mem_re       = 1'b0;
    mem_raddr    = PW_AW'(wpos_q - 1'b1);

    case (state_q)
      S_IDLE: begin
        // Take a beat and fetch its slot word
        if (accept) begin
          mem_re  = slot_hit;
          state_d = S_WR;
        end
      end
      S_WR: begin
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.packet_kind = KIND_FORWARD;
          out_d.out_word    = word_q;
          out_d.out_bytes   = bc_q;
          out_d.out_last    = last_q;
          if (wpos_q == '0) begin
            // Header: claim or pair with the slot
            even_d   = 1'b0;
            paired_d = 1'b0;
            if (nbytes == FULL_BYTES) begin
              cur_seq_d = word_q;
              if (!word_q[0]) begin
                even_d       = 1'b1;
                held_seq_d   = word_q;
                held_valid_d = 1'b1;
                held_len_d   = '0;
              end else if (held_valid_q && (held_seq_q == word_q - 32'd1)) begin
                paired_d = 1'b1;
              end
            end
          end else if (slot_hit && (even_q || paired_q)) begin
            // Payload: store or fold into the slot
            mem_we = 1'b1;
            if (paired_q && (wpos_h <= held_len_q)) begin
              mem_wdata = masked ^ mem_rdata;
            end
            if (held_len_q < wpos_h) begin
              held_len_d = wpos_h;
            end
          end
          if (wpos_q < WPOS_W'(MAX_PACKET_WORDS - 1)) begin
            wpos_d = wpos_q + 1'b1;
          end
          state_d = S_IDLE;
          if (last_q) begin
            // A paired packet ends: start the parity burst
            if (paired_d) begin
              state_d = S_PHDR;
            end
            wpos_d   = '0;
            even_d   = 1'b0;
            paired_d = 1'b0;
          end
        end
      end
      S_PHDR: begin
        // Parity header beat
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.packet_kind = KIND_PARITY;
          out_d.out_word    = cur_seq_q | PARITY_FLAG;
          out_d.out_bytes   = FULL_BYTES;
          out_d.out_last    = 1'b0;
          par_idx_d         = '0;
          state_d           = S_PRD;
        end
      end
      S_PRD: begin
        mem_re    = 1'b1;
        mem_raddr = par_idx_q;
        state_d   = S_PEM;
      end
      S_PEM: begin
        // Slot word beat; unwritten words read as zero
        if (out_free) begin
          out_valid_d       = 1'b1;
          out_d.packet_kind = KIND_PARITY;
          out_d.out_word    = (HLEN_W'(par_idx_q) < held_len_q) ? mem_rdata : 32'h0;
          out_d.out_bytes   = FULL_BYTES;
          out_d.out_last    = par_last;
          if (par_last) begin
            held_valid_d = 1'b0;
            held_len_d   = '0;
            state_d      = S_IDLE;
          end else begin
            par_idx_d = par_idx_q + 1'b1;
            state_d   = S_PRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      held_seq_q   <= '0;
      held_valid_q <= 1'b0;
      held_len_q   <= '0;
      cur_seq_q    <= '0;
      wpos_q       <= '0;
      paired_q     <= 1'b0;
      even_q       <= 1'b0;
      par_idx_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      held_seq_q   <= held_seq_d;
      held_valid_q <= held_valid_d;
      held_len_q   <= held_len_d;
      cur_seq_q    <= cur_seq_d;
      wpos_q       <= wpos_d;
      paired_q     <= paired_d;
      even_q       <= even_d;
      par_idx_q    <= par_idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Capture the accepted beat and the output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= in_i.data_word;
      bc_q   <= in_i.byte_count;
      last_q <= in_i.end_of_packet;
    end
    out_q <= out_d;
  end

  // Slot fill never exceeds the slot
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(held_len_q) <= 32'(PARITY_WORDS))
    else $error("slot length past slot size");

  // A parity burst only runs against a held slot
  a_burst_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRD || state_q == S_PEM || state_q == S_PHDR) |-> held_valid_q)
    else $error("parity burst without held slot");

  // Final parity beat frees the slot
  a_burst_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PEM && out_free && par_last) |=> (!held_valid_q && held_len_q == '0))
    else $error("slot not freed after parity packet");

  // No input taken while a beat is being processed
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_WR && !in_i.ready))
    else $error("input taken during processing");

endmodule
